// File: rtl/core/pkmt_pkg.sv
// Shared types, constants and controller commands for the pair-key map table.
package pkmt_pkg;

    localparam int SLOTS = 16;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = 5;
    localparam int KEY_W = 64;

    localparam logic [4:0] CAP_RESET = 5'd16;

    // request opcodes
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_GET    = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic        [1:0]  opcode;
        logic signed [31:0] key_first;
        logic signed [31:0] key_second;
        logic signed [31:0] data_first;
        logic signed [31:0] data_second;
    } t_in_item;

    typedef struct packed {
        logic        [1:0]       status;
        logic signed [31:0]      found_first;
        logic signed [31:0]      found_second;
        logic        [CNT_W-1:0] entry_total;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_READ_HIT,
        S_READ_LAST,
        S_COMMIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load_req;
        logic search;
        logic find_last;
        logic rd_last;
        logic got_from_mem;
        logic commit;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic remove_hit;
    } t_stat;

endpackage

// File: rtl/core/pkmt_ctrl.sv
// Sequencer for the pair-key map table: request flow and result handshake.
module pkmt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    input  pkmt_pkg::t_stat i_stat,
    output pkmt_pkg::t_cmd  o_cmd
);

    pkmt_pkg::t_state r_state, n_state;
    logic             r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pkmt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            pkmt_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = pkmt_pkg::S_SEARCH;
                end
            end
            pkmt_pkg::S_SEARCH: begin
                o_cmd.search = 1'b1;
                n_state      = pkmt_pkg::S_READ_HIT;
            end
            pkmt_pkg::S_READ_HIT: begin
                o_cmd.find_last = 1'b1;
                n_state = i_stat.remove_hit ? pkmt_pkg::S_READ_LAST : pkmt_pkg::S_COMMIT;
            end
            pkmt_pkg::S_READ_LAST: begin
                o_cmd.rd_last      = 1'b1;
                o_cmd.got_from_mem = 1'b1;
                n_state            = pkmt_pkg::S_COMMIT;
            end
            pkmt_pkg::S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = pkmt_pkg::S_DONE;
            end
            pkmt_pkg::S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = pkmt_pkg::S_IDLE;
                end
            end
            default: n_state = pkmt_pkg::S_IDLE;
        endcase
    end

    // output holding register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_in_stall  = (r_state != pkmt_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

    a_commit_then_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pkmt_pkg::S_COMMIT) |=> (r_state == pkmt_pkg::S_DONE))
        else $error("commit not followed by result stage");

    a_load_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || !i_out_stall))
        else $error("result overwritten while held");

    a_last_only_remove: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pkmt_pkg::S_READ_LAST) |-> $past(i_stat.remove_hit))
        else $error("move read without a remove hit");

endmodule

// File: rtl/core/pkmt_datapath.sv
// Datapath for the pair-key map table: key store, value memory, search and update.
module pkmt_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pkmt_pkg::t_cmd      i_cmd,
    output pkmt_pkg::t_stat     o_stat,
    input  pkmt_pkg::t_in_item  i_in_item,
    input  logic                i_cfg_we,
    input  logic [4:0]          i_cfg_data,
    output pkmt_pkg::t_out_item o_out_item
);

    pkmt_pkg::t_in_item            r_req;
    pkmt_pkg::t_out_item           r_out;
    logic [4:0]                    r_cap;
    logic [pkmt_pkg::CNT_W-1:0]    r_count, n_count;
    logic [pkmt_pkg::SLOTS-1:0]    r_valid, n_valid;
    logic [pkmt_pkg::KEY_W-1:0]    r_key [pkmt_pkg::SLOTS];
    logic [pkmt_pkg::KEY_W-1:0]    r_value_mem [pkmt_pkg::SLOTS];
    logic [pkmt_pkg::KEY_W-1:0]    r_rd_data;
    logic                          r_hit, r_free_ok;
    logic [pkmt_pkg::IDX_W-1:0]    r_hit_idx, r_free_idx, r_last_idx;
    logic [1:0]                    r_status, n_status;
    logic [pkmt_pkg::KEY_W-1:0]    r_got;

    logic [pkmt_pkg::CNT_W-1:0]    lim;
    logic [pkmt_pkg::KEY_W-1:0]    req_key, req_val;
    logic                          hit_c, free_c;
    logic [pkmt_pkg::IDX_W-1:0]    hit_idx_c, free_idx_c, last_c;
    logic                          mem_we, key_we;
    logic [pkmt_pkg::IDX_W-1:0]    mem_wa, mem_ra, key_wa;
    logic [pkmt_pkg::KEY_W-1:0]    mem_wd, key_wd;

    assign lim     = (r_cap > pkmt_pkg::CNT_W'(pkmt_pkg::SLOTS)) ?
                     pkmt_pkg::CNT_W'(pkmt_pkg::SLOTS) : r_cap;
    assign req_key = {r_req.key_first, r_req.key_second};
    assign req_val = {r_req.data_first, r_req.data_second};

    // lowest matching slot and lowest free slot within the live range
    always_comb begin
        hit_c      = 1'b0;
        hit_idx_c  = '0;
        free_c     = 1'b0;
        free_idx_c = '0;
        for (int i = pkmt_pkg::SLOTS - 1; i >= 0; i--) begin
            if ((i < int'(lim)) && r_valid[i] && (r_key[i] == req_key)) begin
                hit_c     = 1'b1;
                hit_idx_c = pkmt_pkg::IDX_W'(i);
            end
            if ((i < int'(lim)) && !r_valid[i]) begin
                free_c     = 1'b1;
                free_idx_c = pkmt_pkg::IDX_W'(i);
            end
        end
    end

    // highest valid slot at or above the hit, used to refill the hole
    always_comb begin
        last_c = r_hit_idx;
        for (int i = 0; i < pkmt_pkg::SLOTS; i++) begin
            if (r_valid[i] && (i < int'(lim)) && (i >= int'(r_hit_idx))) begin
                last_c = pkmt_pkg::IDX_W'(i);
            end
        end
    end

    always_comb begin
        n_status = pkmt_pkg::ST_MISS;
        n_count  = r_count;
        n_valid  = r_valid;
        mem_we   = 1'b0;
        mem_wa   = r_hit_idx;
        mem_wd   = req_val;
        key_we   = 1'b0;
        key_wa   = r_hit_idx;
        key_wd   = req_key;
        unique case (r_req.opcode)
            pkmt_pkg::OP_ADD: begin
                if (r_hit) begin
                    mem_we   = 1'b1;
                    n_status = pkmt_pkg::ST_OK;
                end else if (r_free_ok) begin
                    mem_we              = 1'b1;
                    mem_wa              = r_free_idx;
                    key_we              = 1'b1;
                    key_wa              = r_free_idx;
                    n_valid[r_free_idx] = 1'b1;
                    n_count             = r_count + 1'b1;
                    n_status            = pkmt_pkg::ST_OK;
                end else begin
                    n_status = pkmt_pkg::ST_FULL;
                end
            end
            pkmt_pkg::OP_REMOVE: begin
                if (r_hit) begin
                    mem_we              = 1'b1;
                    mem_wd              = r_rd_data;
                    key_we              = 1'b1;
                    key_wd              = r_key[r_last_idx];
                    n_valid[r_last_idx] = 1'b0;
                    if (r_count != '0) begin
                        n_count = r_count - 1'b1;
                    end
                    n_status = pkmt_pkg::ST_OK;
                end
            end
            pkmt_pkg::OP_GET: begin
                if (r_hit) begin
                    n_status = pkmt_pkg::ST_OK;
                end
            end
            default: n_status = pkmt_pkg::ST_MISS;
        endcase
        if (!i_cmd.commit) begin
            mem_we = 1'b0;
            key_we = 1'b0;
        end
    end

    assign mem_ra = i_cmd.rd_last ? r_last_idx : r_hit_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= pkmt_pkg::CAP_RESET;
            r_count <= '0;
            r_valid <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (i_cmd.commit) begin
                r_count <= n_count;
                r_valid <= n_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= i_in_item;
        end
        if (i_cmd.search) begin
            r_hit      <= hit_c;
            r_hit_idx  <= hit_idx_c;
            r_free_ok  <= free_c && (r_count < lim);
            r_free_idx <= free_idx_c;
        end
        if (i_cmd.find_last) begin
            r_last_idx <= last_c;
        end
        if (key_we) begin
            r_key[key_wa] <= key_wd;
        end
        if (i_cmd.got_from_mem) begin
            r_got <= r_rd_data;
        end else if (i_cmd.commit && !o_stat.remove_hit) begin
            r_got <= (r_hit && (r_req.opcode == pkmt_pkg::OP_GET)) ? r_rd_data : '0;
        end
        if (i_cmd.commit) begin
            r_status <= n_status;
        end
        if (i_cmd.load_out) begin
            r_out.status       <= r_status;
            r_out.found_first  <= $signed(r_got[pkmt_pkg::KEY_W-1:32]);
            r_out.found_second <= $signed(r_got[31:0]);
            r_out.entry_total  <= r_count;
        end
    end

    // value store, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_value_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_value_mem[mem_ra];
    end

    assign o_stat.remove_hit = r_hit && (r_req.opcode == pkmt_pkg::OP_REMOVE);
    assign o_out_item        = r_out;

    a_count_matches_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_count))
        else $error("entry count differs from valid marks");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= pkmt_pkg::SLOTS)
        else $error("entry count above slot count");

    a_single_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.commit |=> $stable(r_valid))
        else $error("valid marks changed outside commit");

endmodule

// File: rtl/core/pair_key_map_table.sv
// Top level of the pair-key map table: sequencer plus datapath.
//
// Fixed-capacity map, 16 slots, keyed by a pair of 32-bit words, each key
// holding a pair of 32-bit values. One request item in, one result item out.
// Input channel: i_in_valid / o_in_stall with i_in_item (opcode add, remove
// or get, key pair, data pair). Output channel: o_out_valid / i_out_stall
// with o_out_item (status, fetched or removed value, entry count after it).
// Config: i_cfg_valid / o_cfg_ready write capacity_limit (always ready);
// write it only while the block is idle. Capacity above 16 saturates.
// An accepted item passes SEARCH, READ_HIT, READ_LAST (remove hits only),
// COMMIT and DONE; the next item is taken only once the sequencer is back in IDLE.
// The value memory has one registered read port: the hit value and, on
// remove, the refill value are read in separate cycles before the commit
// cycle. One item is in work at a time.
// The result sits in an output register, so the next item is accepted as
// soon as the result is loaded, even if the receiver still stalls; a
// further result waits in the sequencer until that register is taken.
// Reset (synchronous, active low) clears the valid marks, the entry count
// and the handshake state, and sets the capacity to 16; key and value
// contents are left as they are and only read behind a valid mark.
module pair_key_map_table (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pkmt_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pkmt_pkg::t_out_item o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [4:0]          i_cfg_data
);

    pkmt_pkg::t_cmd  cmd;
    pkmt_pkg::t_stat stat;

    // sequencer: IDLE, SEARCH, READ_HIT, (READ_LAST), COMMIT, DONE
    pkmt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // parallel key compare, value memory and result register
    pkmt_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_in_item  (i_in_item),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_out_item (o_out_item)
    );

    // capacity register takes a write in any cycle
    assign o_cfg_ready = 1'b1;

endmodule

// File: verif/pair_key_map_table_check.sv
// Checker for the pair-key map table: table predictor and in-order result compare.
module pair_key_map_table_check (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  pkmt_pkg::t_in_item  i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  pkmt_pkg::t_out_item i_out_item,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [4:0]          i_cfg_data,
    output int                  o_fail_count,
    output int                  o_pending
);

    // shadow copy of the table
    logic [63:0]                shadow_key [pkmt_pkg::SLOTS];
    logic [63:0]                shadow_val [pkmt_pkg::SLOTS];
    logic                       shadow_used [pkmt_pkg::SLOTS];
    logic [pkmt_pkg::CNT_W-1:0] shadow_count;
    logic [4:0]                 shadow_cap;

    pkmt_pkg::t_out_item pending_results [$];
    int                  fails = 0;
    int                  accepted_items = 0;
    int                  taken_results = 0;

    assign o_fail_count = fails;
    assign o_pending    = accepted_items - taken_results;

    // Applies one request to the shadow table and returns the response.
    function automatic pkmt_pkg::t_out_item table_response(input pkmt_pkg::t_in_item req);
        logic [63:0]         key;
        logic [63:0]         val;
        logic [63:0]         got;
        int                  lim;
        int                  hit;
        int                  last;
        int                  i;
        logic                placed;
        pkmt_pkg::t_out_item rsp;
        key    = {req.key_first, req.key_second};
        val    = {req.data_first, req.data_second};
        got    = '0;
        lim    = (shadow_cap < pkmt_pkg::SLOTS) ? int'(shadow_cap) : pkmt_pkg::SLOTS;
        hit    = -1;
        placed = 1'b0;
        rsp.status = pkmt_pkg::ST_MISS;
        for (i = 0; i < lim; i++)
            if (hit < 0 && shadow_used[i] && shadow_key[i] == key)
                hit = i;
        case (req.opcode)
            pkmt_pkg::OP_ADD: begin
                if (hit >= 0) begin
                    shadow_val[hit] = val;
                    rsp.status = pkmt_pkg::ST_OK;
                end else begin
                    rsp.status = pkmt_pkg::ST_FULL;
                    if (int'(shadow_count) < lim) begin
                        for (i = 0; i < lim; i++) begin
                            if (!placed && !shadow_used[i]) begin
                                shadow_key[i]  = key;
                                shadow_val[i]  = val;
                                shadow_used[i] = 1'b1;
                                shadow_count   = shadow_count + 1'b1;
                                rsp.status     = pkmt_pkg::ST_OK;
                                placed         = 1'b1;
                            end
                        end
                    end
                end
            end
            pkmt_pkg::OP_REMOVE: begin
                if (hit >= 0) begin
                    got = shadow_val[hit];
                    if (shadow_count != 0)
                        shadow_count = shadow_count - 1'b1;
                    // highest valid slot in range refills the hole
                    last = hit;
                    for (i = hit; i < lim; i++)
                        if (shadow_used[i])
                            last = i;
                    shadow_key[hit]   = shadow_key[last];
                    shadow_val[hit]   = shadow_val[last];
                    shadow_used[last] = 1'b0;
                    rsp.status = pkmt_pkg::ST_OK;
                end
            end
            pkmt_pkg::OP_GET: begin
                if (hit >= 0) begin
                    got = shadow_val[hit];
                    rsp.status = pkmt_pkg::ST_OK;
                end
            end
            default: begin
            end
        endcase
        rsp.found_first  = got[63:32];
        rsp.found_second = got[31:0];
        rsp.entry_total  = shadow_count;
        return rsp;
    endfunction

    task automatic compare_word(input string label, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got) begin
            fails++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, label, want, got);
        end
    endtask

    always @(posedge i_clk) begin : track
        pkmt_pkg::t_out_item want;
        int                  i;
        if (!i_rst_n) begin
            for (i = 0; i < pkmt_pkg::SLOTS; i++)
                shadow_used[i] = 1'b0;
            shadow_count = '0;
            shadow_cap   = pkmt_pkg::CAP_RESET;
            pending_results.delete();
            accepted_items <= 0;
            taken_results  <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                shadow_cap = i_cfg_data;
            if (i_out_valid && !i_out_stall) begin
                taken_results <= taken_results + 1;
                if (pending_results.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected item, expected none actual %h",
                             $time, i_out_item);
                end else begin
                    want = pending_results.pop_front();
                    compare_word("status", 32'(want.status), 32'(i_out_item.status));
                    compare_word("found_first", want.found_first, i_out_item.found_first);
                    compare_word("found_second", want.found_second, i_out_item.found_second);
                    compare_word("entry_total", 32'(want.entry_total),
                                 32'(i_out_item.entry_total));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                pending_results.push_back(table_response(i_in_item));
                accepted_items <= accepted_items + 1;
            end
        end
    end

endmodule

// File: verif/pair_key_map_table_test.sv
// Testbench top for the pair-key map table: clock, reset, stimulus and verdict.
module pair_key_map_table_test;

    // opcode 3 is not decoded by the block; it must answer miss and change nothing
    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         KEY_POOL    = 24;
    localparam int         SEGMENTS    = 7;
    localparam int         SEG_ITEMS   = 250;
    localparam int         HOLD_CYCLES = 300;
    localparam int         DRAIN_WAIT  = 12;
    localparam int         CYCLE_LIMIT = 400000;

    // corner keys and values
    localparam logic [63:0] K_MIN   = 64'h8000_0000_8000_0000;
    localparam logic [63:0] K_MAX   = 64'h7FFF_FFFF_7FFF_FFFF;
    localparam logic [63:0] K_ZERO  = 64'h0;
    localparam logic [63:0] K_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] K_MIXED = 64'h8000_0000_7FFF_FFFF;
    localparam logic [63:0] V_MAX   = 64'h7FFF_FFFF_7FFF_FFFF;
    localparam logic [63:0] V_MIN   = 64'h8000_0000_8000_0000;
    localparam logic [63:0] V_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] V_ALT   = 64'h5555_5555_AAAA_AAAA;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    pkmt_pkg::t_in_item  in_item = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    pkmt_pkg::t_out_item out_item;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [4:0]          cfg_data = '0;

    int fail_count;
    int pending;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_req = 1'b0;
    int cycle_count = 0;

    logic [63:0] key_pool [KEY_POOL];
    // capacity per random segment: nominal, small, saturating, one, zero, just above, twelve
    logic [4:0]  seg_caps [SEGMENTS] = '{5'd16, 5'd5, 5'd31, 5'd1, 5'd0, 5'd17, 5'd12};

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    pair_key_map_table dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    pair_key_map_table_check checker_inst (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Offers one item, with random idle cycles ahead of it, and returns at the
    // edge where it is taken. Valid stays high so back-to-back items need no
    // second assignment in the same step.
    task automatic send_request(input pkmt_pkg::t_in_item req);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic issue(input logic [1:0] op, input logic [63:0] key,
                         input logic [63:0] val);
        pkmt_pkg::t_in_item req;
        req.opcode      = op;
        req.key_first   = key[63:32];
        req.key_second  = key[31:0];
        req.data_first  = val[63:32];
        req.data_second = val[31:0];
        send_request(req);
    endtask

    // Capacity is only written with the block idle: input lowered and every
    // result taken. The pending count is registered, so a zero read here means
    // the last result has already been taken.
    task automatic set_capacity(input logic [4:0] cap);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly pool keys so hits, updates and full tables are common; the rest
    // are fresh keys that almost always miss.
    function automatic pkmt_pkg::t_in_item random_request();
        pkmt_pkg::t_in_item req;
        int unsigned        pick;
        logic [63:0]        key;
        pick = $urandom_range(99);
        if (pick < 45)
            req.opcode = pkmt_pkg::OP_ADD;
        else if (pick < 70)
            req.opcode = pkmt_pkg::OP_REMOVE;
        else if (pick < 95)
            req.opcode = pkmt_pkg::OP_GET;
        else
            req.opcode = OP_UNUSED;
        if ($urandom_range(99) < 80)
            key = key_pool[$urandom_range(KEY_POOL - 1)];
        else
            key = {$urandom, $urandom};
        req.key_first   = key[63:32];
        req.key_second  = key[31:0];
        req.data_first  = $urandom;
        req.data_second = $urandom;
        return req;
    endfunction

    // Receiver: random stall per cycle, or a long hold-off on request so the
    // output register and the sequencer both fill and the input stalls.
    initial begin
        @(posedge clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
                @(posedge clk);
            end
        end
    end

    // Watchdog.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("pair_key_map_table_test NOT OK");
        $finish;
    end

    initial begin
        int seg;
        int n;
        int k;
        // pool keys share halves in places so a match on one word alone is caught
        for (k = 0; k < KEY_POOL; k++) begin
            key_pool[k][63:32] = (k % 3 == 0) ? 32'h8000_0000 : $urandom;
            key_pool[k][31:0]  = (k % 5 == 0) ? 32'h7FFF_FFFF : $urandom;
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part, capacity at its reset value of 16 ----
        issue(pkmt_pkg::OP_GET, K_MIN, V_MAX);        // empty table misses
        issue(pkmt_pkg::OP_REMOVE, K_MIN, V_MAX);
        issue(OP_UNUSED, K_MIN, V_MAX);               // undecoded opcode
        issue(pkmt_pkg::OP_ADD, K_MIN, V_MAX);
        issue(pkmt_pkg::OP_ADD, K_MAX, V_MIN);
        issue(pkmt_pkg::OP_ADD, K_ZERO, V_ONES);
        issue(pkmt_pkg::OP_ADD, K_ONES, K_ZERO);
        issue(pkmt_pkg::OP_ADD, K_MIXED, V_ALT);      // shares one word with K_MIN and K_MAX
        issue(pkmt_pkg::OP_GET, K_MAX, K_ZERO);
        issue(pkmt_pkg::OP_ADD, K_MAX, V_ALT);        // update in place
        issue(pkmt_pkg::OP_GET, K_MAX, K_ZERO);
        issue(pkmt_pkg::OP_REMOVE, K_MIN, K_ZERO);    // hole at slot 0 refilled from the top
        issue(pkmt_pkg::OP_REMOVE, K_ONES, K_ZERO);   // highest entry, just cleared
        issue(pkmt_pkg::OP_GET, K_MIN, K_ZERO);
        issue(OP_UNUSED, K_MAX, V_MAX);               // present key, still a miss

        // three entries fill a capacity of three
        set_capacity(5'd3);
        issue(pkmt_pkg::OP_ADD, K_ONES, V_ONES);      // full
        issue(pkmt_pkg::OP_ADD, K_ZERO, V_MIN);       // update still allowed when full
        issue(pkmt_pkg::OP_REMOVE, K_MAX, K_ZERO);
        issue(pkmt_pkg::OP_ADD, K_ONES, V_ONES);

        // zero capacity hides every slot
        set_capacity(5'd0);
        issue(pkmt_pkg::OP_GET, K_ZERO, K_ZERO);
        issue(pkmt_pkg::OP_ADD, K_MIN, V_MAX);
        issue(pkmt_pkg::OP_REMOVE, K_ZERO, K_ZERO);

        // above the slot count saturates to 16
        set_capacity(5'd31);
        issue(pkmt_pkg::OP_GET, K_ONES, K_ZERO);
        issue(pkmt_pkg::OP_ADD, K_MIN, V_MAX);

        // ---- random part ----
        for (seg = 0; seg < SEGMENTS; seg++) begin
            set_capacity(seg_caps[seg]);
            if (seg < 2) begin
                send_idle_pct = 23;
                recv_idle_pct = 53;
            end else if (seg < 4) begin
                send_idle_pct = 53;
                recv_idle_pct = 23;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (n = 0; n < SEG_ITEMS; n++) begin
                if (n == 100 && (seg == 0 || seg == 5))
                    hold_req = 1'b1;
                send_request(random_request());
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0)
            $display("pair_key_map_table_test OK");
        else
            $display("pair_key_map_table_test NOT OK");
        $finish;
    end

endmodule

// File: pair_key_map_table.f
rtl/core/pkmt_pkg.sv
rtl/core/pkmt_ctrl.sv
rtl/core/pkmt_datapath.sv
rtl/core/pair_key_map_table.sv
verif/pair_key_map_table_check.sv
verif/pair_key_map_table_test.sv
